// File: src/pso_pkg.sv
// ----------------------------------------------------------------------------
// pso_pkg: shared definitions for the particle update block
// Widths, reset values, register indexes, item kinds and the sequencer
// states used by the particle update block and its helper modules.
// ----------------------------------------------------------------------------
package pso_pkg;

  // Default number of stored dimensions.
  localparam int DIMENSIONS_DEFAULT = 16;

  // Velocity limit is this multiple of the vmax_fraction register.
  localparam int VMAX_MULT = 3;

  // Stream payload widths.
  localparam int KIND_W     = 2;
  localparam int DIM_W      = 4;
  localparam int IN_DATA_W  = 168;
  localparam int OUT_DATA_W = 72;

  // Configuration port widths.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_MOMENTUM        = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OWN_BEST_GAIN   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SWARM_BEST_GAIN = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_VMAX_FRACTION   = 2'd3;

  // Register reset values.
  localparam logic [CFG_DATA_W-1:0] MOMENTUM_RESET        = 16'd2867;
  localparam logic [CFG_DATA_W-1:0] OWN_BEST_GAIN_RESET   = 16'd6144;
  localparam logic [CFG_DATA_W-1:0] SWARM_BEST_GAIN_RESET = 16'd6144;
  localparam logic [CFG_DATA_W-1:0] VMAX_FRACTION_RESET   = 16'd6554;

  // Best cost before any report: largest positive value.
  localparam logic signed [31:0] BEST_COST_RESET = 32'sh7FFF_FFFF;

  // Shared multiplier operand and product widths.
  localparam int MUL_A_W = 33;
  localparam int MUL_B_W = 21;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;

  // Item kinds carried on tuser.
  typedef enum logic [KIND_W-1:0] {
    KIND_LOAD = 2'd0,
    KIND_COST = 2'd1,
    KIND_STEP = 2'd2
  } kind_t;

  // Sequencer states.
  typedef enum logic [3:0] {
    S_IDLE,
    S_READ,
    S_FETCH,
    S_MV,
    S_G1,
    S_T1,
    S_G2,
    S_T2,
    S_SUM,
    S_CLAMP,
    S_WRITE,
    S_DONE
  } state_t;

endpackage

// File: src/pso_particle_update.sv
// ----------------------------------------------------------------------------
// pso_particle_update: one particle of a swarm optimizer
// Holds position, velocity and personal-best vectors and the best cost, and
// applies load, cost report and velocity step requests.
// ----------------------------------------------------------------------------
// One request is handled at a time. A load, a cost report or an unused kind
// passes the registered RAM read, fetch and done states; a velocity step also
// runs its five dependent multiplies (m*v, c1*r1, g1*diff, c2*r2, g2*diff),
// which all pass through a single registered 33x21 multiplier, then the clamp
// and the write back. Position and velocity live in one RAM, the personal best
// in another. A cost report that improves the best does not copy the vector:
// per-dimension flag bits record which entries have moved since the last
// snapshot, and an entry saves its old position into the best RAM on its
// first write after the snapshot. Flag bits clear at reset, so there is no
// clearing pass. Results are held in an output register, and a finished
// result waits there until it is taken.
// ----------------------------------------------------------------------------
module pso_particle_update #(
  parameter int DIMENSIONS = pso_pkg::DIMENSIONS_DEFAULT
) (
  input  logic                               clk,
  input  logic                               rst,
  // Request stream.
  input  logic                               s_tvalid,
  output logic                               s_tready,
  // tdata from bit 0: dim[3:0], load_position[35:4], load_velocity[67:36],
  // global_best[99:68], rand_own[115:100], rand_global[131:116],
  // cost[163:132], zero fill[167:164].
  input  logic [pso_pkg::IN_DATA_W-1:0]      s_tdata,
  // tuser from bit 0: kind[1:0].
  input  logic [pso_pkg::KIND_W-1:0]         s_tuser,
  // Result stream.
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // tdata from bit 0: new_position[31:0], new_velocity[63:32],
  // improved[64], clamped[65], zero fill[71:66].
  output logic [pso_pkg::OUT_DATA_W-1:0]     m_tdata,
  // Configuration write port.
  input  logic                               cfg_we,
  input  logic [pso_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [pso_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int IDX_W = (DIMENSIONS > 1) ? $clog2(DIMENSIONS) : 1;
  localparam int PV_W  = 64;

  // Saturate a wide signed value to 32 bits.
  function automatic logic signed [31:0] sat32(input logic signed [pso_pkg::MUL_P_W-1:0] val);
    if (val > 54'sd2147483647) begin
      return 32'sh7FFF_FFFF;
    end else if (val < -54'sd2147483648) begin
      return 32'sh8000_0000;
    end else begin
      return val[31:0];
    end
  endfunction

  pso_pkg::state_t state, state_next;

  // Configuration registers.
  logic [15:0] momentum, own_best_gain, swarm_best_gain, vmax_fraction;

  // Captured request.
  logic [pso_pkg::KIND_W-1:0] item_kind;
  logic [pso_pkg::DIM_W-1:0]  item_dim;
  logic signed [31:0]         item_lpos, item_lvel, item_gbest, item_cost;
  logic [15:0]                item_r1, item_r2;

  // Particle state held in flip-flops.
  logic signed [31:0]      best_cost;
  logic                    has_best;
  logic [DIMENSIONS-1:0]   written;
  logic [DIMENSIONS-1:0]   moved;

  // Working registers.
  logic signed [31:0] x_r, v_r, pbest_r, vnew;
  logic signed [33:0] acc;
  logic signed [31:0] res_pos, res_vel;
  logic               res_improved, res_clamped;

  // RAM and multiplier connections.
  logic                             pv_we, best_we;
  logic [PV_W-1:0]                  pv_wdata, pv_rdata;
  logic [31:0]                      best_wdata, best_rdata;
  logic signed [pso_pkg::MUL_A_W-1:0] mul_a;
  logic signed [pso_pkg::MUL_B_W-1:0] mul_b;
  logic signed [pso_pkg::MUL_P_W-1:0] prod;

  // Combinational helpers.
  logic [6:0]          dim_ext;
  logic [IDX_W-1:0]    addr;
  logic                dim_ok, lower, out_free;
  logic signed [31:0]  x_eff, v_eff, pbest_eff;
  logic signed [32:0]  diff_own, diff_glob, pos_sum;
  logic signed [31:0]  term_mv, term_att, vclamp, pos_new;
  logic [17:0]         vmax;
  logic signed [33:0]  vmax_ext;
  logic                hit;

  assign s_tready = (state == pso_pkg::S_IDLE);
  assign out_free = !m_tvalid || m_tready;

  // Address decode and range check.
  assign dim_ext = 7'(item_dim);
  assign addr    = dim_ext[IDX_W-1:0];
  assign dim_ok  = 32'(item_dim) < 32'(DIMENSIONS);
  assign lower   = item_cost < best_cost;

  // Effective stored values: unwritten entries read as zero, and an entry not
  // moved since the last snapshot has its best equal to its position.
  assign x_eff     = written[addr] ? signed'(pv_rdata[31:0]) : 32'sd0;
  assign v_eff     = written[addr] ? signed'(pv_rdata[63:32]) : 32'sd0;
  assign pbest_eff = moved[addr] ? signed'(best_rdata) : x_eff;

  // Attraction differences, exact in 33 bits.
  assign diff_own  = 33'(pbest_r) - 33'(x_r);
  assign diff_glob = 33'(item_gbest) - 33'(x_r);

  // Scaled terms from the registered product.
  assign term_mv  = sat32(prod >>> 12);
  assign term_att = sat32(prod >>> 16);

  // Velocity limit and clamp.
  assign vmax     = 18'(vmax_fraction) * 18'(pso_pkg::VMAX_MULT);
  assign vmax_ext = signed'(34'(vmax));
  always_comb begin
    hit    = 1'b0;
    vclamp = acc[31:0];
    if (acc > vmax_ext) begin
      hit    = 1'b1;
      vclamp = vmax_ext[31:0];
    end else if (acc < -vmax_ext) begin
      hit    = 1'b1;
      vclamp = 32'(-vmax_ext);
    end
  end

  // New position, saturated.
  assign pos_sum = 33'(x_r) + 33'(vnew);
  assign pos_new = sat32(pso_pkg::MUL_P_W'(pos_sum));

  // Position/velocity RAM: position in the low half.
  pso_ram #(.WIDTH(PV_W), .DEPTH(DIMENSIONS)) u_pv_ram (
    .clk   (clk),
    .we    (pv_we),
    .waddr (addr),
    .wdata (pv_wdata),
    .raddr (addr),
    .rdata (pv_rdata)
  );

  // Personal-best RAM, valid only for moved entries.
  pso_ram #(.WIDTH(32), .DEPTH(DIMENSIONS)) u_best_ram (
    .clk   (clk),
    .we    (best_we),
    .waddr (addr),
    .wdata (best_wdata),
    .raddr (addr),
    .rdata (best_rdata)
  );

  // Shared multiplier.
  pso_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (prod)
  );

  // Next-state logic.
  always_comb begin
    state_next = state;
    case (state)
      pso_pkg::S_IDLE: begin
        if (s_tvalid) state_next = pso_pkg::S_READ;
      end
      pso_pkg::S_READ:  state_next = pso_pkg::S_FETCH;
      pso_pkg::S_FETCH: begin
        if (item_kind == pso_pkg::KIND_STEP && dim_ok) state_next = pso_pkg::S_MV;
        else state_next = pso_pkg::S_DONE;
      end
      pso_pkg::S_MV:    state_next = pso_pkg::S_G1;
      pso_pkg::S_G1:    state_next = pso_pkg::S_T1;
      pso_pkg::S_T1:    state_next = pso_pkg::S_G2;
      pso_pkg::S_G2:    state_next = pso_pkg::S_T2;
      pso_pkg::S_T2:    state_next = pso_pkg::S_SUM;
      pso_pkg::S_SUM:   state_next = pso_pkg::S_CLAMP;
      pso_pkg::S_CLAMP: state_next = pso_pkg::S_WRITE;
      pso_pkg::S_WRITE: state_next = pso_pkg::S_DONE;
      pso_pkg::S_DONE: begin
        if (out_free) state_next = pso_pkg::S_IDLE;
      end
      default: state_next = pso_pkg::S_IDLE;
    endcase
  end

  // Datapath controls: RAM writes and multiplier operands per state. Each
  // product is registered, so it is used one state after it is started.
  always_comb begin
    pv_we      = 1'b0;
    best_we    = 1'b0;
    pv_wdata   = {item_lvel, item_lpos};
    best_wdata = x_eff;
    mul_a      = '0;
    mul_b      = '0;
    case (state)
      pso_pkg::S_FETCH: begin
        if (item_kind == pso_pkg::KIND_LOAD && dim_ok) begin
          pv_we   = 1'b1;
          best_we = !moved[addr];
        end
      end
      pso_pkg::S_MV: begin
        mul_a = 33'(v_r);
        mul_b = signed'(21'(momentum));
      end
      pso_pkg::S_G1: begin
        // m*v is consumed here while c1*r1 starts.
        mul_a = signed'(33'(own_best_gain));
        mul_b = signed'(21'(item_r1));
      end
      pso_pkg::S_T1: begin
        mul_a = diff_own;
        mul_b = signed'({1'b0, prod[31:12]});
      end
      pso_pkg::S_G2: begin
        mul_a = signed'(33'(swarm_best_gain));
        mul_b = signed'(21'(item_r2));
      end
      pso_pkg::S_T2: begin
        mul_a = diff_glob;
        mul_b = signed'({1'b0, prod[31:12]});
      end
      pso_pkg::S_WRITE: begin
        pv_we      = 1'b1;
        best_we    = !moved[addr];
        pv_wdata   = {vnew, pos_new};
        best_wdata = x_r;
      end
      default: begin
      end
    endcase
  end

  // Capture of an accepted request.
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      item_kind  <= s_tuser;
      item_dim   <= s_tdata[3:0];
      item_lpos  <= signed'(s_tdata[35:4]);
      item_lvel  <= signed'(s_tdata[67:36]);
      item_gbest <= signed'(s_tdata[99:68]);
      item_r1    <= s_tdata[115:100];
      item_r2    <= s_tdata[131:116];
      item_cost  <= signed'(s_tdata[163:132]);
    end
  end

  // Control state, particle flags and configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= pso_pkg::S_IDLE;
      momentum        <= pso_pkg::MOMENTUM_RESET;
      own_best_gain   <= pso_pkg::OWN_BEST_GAIN_RESET;
      swarm_best_gain <= pso_pkg::SWARM_BEST_GAIN_RESET;
      vmax_fraction   <= pso_pkg::VMAX_FRACTION_RESET;
      best_cost       <= pso_pkg::BEST_COST_RESET;
      has_best        <= 1'b0;
      written         <= '0;
      moved           <= '0;
      m_tvalid        <= 1'b0;
    end else begin
      state <= state_next;

      // Register writes.
      if (cfg_we) begin
        case (cfg_index)
          pso_pkg::CFG_MOMENTUM:        momentum        <= cfg_data;
          pso_pkg::CFG_OWN_BEST_GAIN:   own_best_gain   <= cfg_data;
          pso_pkg::CFG_SWARM_BEST_GAIN: swarm_best_gain <= cfg_data;
          pso_pkg::CFG_VMAX_FRACTION:   vmax_fraction   <= cfg_data;
          default: begin
          end
        endcase
      end

      // Best snapshot: an improving cost report, or the first step.
      if (state == pso_pkg::S_READ) begin
        if (item_kind == pso_pkg::KIND_COST && lower) begin
          best_cost <= item_cost;
          has_best  <= 1'b1;
          moved     <= '0;
        end else if (item_kind == pso_pkg::KIND_STEP && dim_ok && !has_best) begin
          if (lower) best_cost <= item_cost;
          has_best <= 1'b1;
          moved    <= '0;
        end
      end

      // Entry flags follow every position write.
      if ((state == pso_pkg::S_FETCH && item_kind == pso_pkg::KIND_LOAD && dim_ok) ||
          state == pso_pkg::S_WRITE) begin
        written[addr] <= 1'b1;
        moved[addr]   <= 1'b1;
      end

      // Output valid.
      if (state == pso_pkg::S_DONE && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Arithmetic and result registers.
  always_ff @(posedge clk) begin
    case (state)
      pso_pkg::S_READ: begin
        res_improved <= (item_kind == pso_pkg::KIND_COST) && lower;
        res_clamped  <= 1'b0;
      end
      pso_pkg::S_FETCH: begin
        x_r     <= x_eff;
        v_r     <= v_eff;
        pbest_r <= pbest_eff;
        if (!dim_ok) begin
          res_pos <= 32'sd0;
          res_vel <= 32'sd0;
        end else if (item_kind == pso_pkg::KIND_LOAD) begin
          res_pos <= item_lpos;
          res_vel <= item_lvel;
        end else begin
          res_pos <= x_eff;
          res_vel <= v_eff;
        end
      end
      pso_pkg::S_G1:  acc <= 34'(term_mv);
      pso_pkg::S_G2:  acc <= acc + 34'(term_att);
      pso_pkg::S_SUM: acc <= acc + 34'(term_att);
      pso_pkg::S_CLAMP: begin
        vnew        <= vclamp;
        res_clamped <= hit;
      end
      pso_pkg::S_WRITE: begin
        res_pos <= pos_new;
        res_vel <= vnew;
      end
      pso_pkg::S_DONE: begin
        if (out_free) begin
          m_tdata <= {6'b0, res_clamped, res_improved, res_vel, res_pos};
        end
      end
      default: begin
      end
    endcase
  end

  // Once a personal best exists it is never dropped.
  assert property (@(posedge clk) disable iff (rst) $past(has_best) |-> has_best)
    else $error("has_best fell outside reset");

  // The written-back velocity always lies within the configured limit.
  assert property (@(posedge clk) disable iff (rst)
    (state == pso_pkg::S_WRITE) |-> (34'(vnew) <= vmax_ext) && (34'(vnew) >= -vmax_ext))
    else $error("step velocity outside the limit");

  // Only a cost report can mark an improvement.
  assert property (@(posedge clk) disable iff (rst)
    (state == pso_pkg::S_DONE) && res_improved |-> (item_kind == pso_pkg::KIND_COST))
    else $error("improved set for a request that is not a cost report");

  // Only a step can report a clamped velocity.
  assert property (@(posedge clk) disable iff (rst)
    (state == pso_pkg::S_DONE) && res_clamped |-> (item_kind == pso_pkg::KIND_STEP))
    else $error("clamped set for a request that is not a step");

  // A result is loaded only when the output register is free.
  assert property (@(posedge clk) disable iff (rst)
    (state == pso_pkg::S_DONE) && m_tvalid && !m_tready |=> (state == pso_pkg::S_DONE))
    else $error("sequencer left the done state while a result was pending");

endmodule

// File: src/pso_ram.sv
// ----------------------------------------------------------------------------
// pso_ram: generic single-write, single-read RAM
// One write port and one read port with a registered read data output.
// ----------------------------------------------------------------------------
module pso_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// File: src/pso_mul.sv
// ----------------------------------------------------------------------------
// pso_mul: shared signed multiplier
// Signed 33 by 21 bit multiply with a registered product; every product of
// the velocity update goes through this one unit in turn.
// ----------------------------------------------------------------------------
module pso_mul (
  input  logic                                clk,
  input  logic signed [pso_pkg::MUL_A_W-1:0]  a,
  input  logic signed [pso_pkg::MUL_B_W-1:0]  b,
  output logic signed [pso_pkg::MUL_P_W-1:0]  p
);

  // Full-width signed product, registered.
  always_ff @(posedge clk) begin
    p <= pso_pkg::MUL_P_W'(a) * pso_pkg::MUL_P_W'(b);
  end

endmodule

// File: tb/pso_particle_update_test.sv
// ----------------------------------------------------------------------------
// pso_particle_update_test: self-checking bench for the particle update block
// Drives load, cost report, step and unused-kind requests into the block with
// random gaps on the request and result streams. Every result is compared
// with a cycle-free predictor of the particle's position, velocity and
// personal-best state, over several register settings including the extremes.
// ----------------------------------------------------------------------------
module pso_particle_update_test;

  localparam int RESET_CYCLES  = 7;
  localparam int SETTLE_CYCLES = 24;
  localparam int LIMIT_CYCLES  = 300000;
  localparam int PHASE_ITEMS   = 110;
  localparam int NUM_PHASES    = 5;
  localparam int NUM_DIMS      = pso_pkg::DIMENSIONS_DEFAULT;
  localparam int MAX_REPORTS   = 10;

  // Kind code the block does not define; it must leave the state alone.
  localparam logic [pso_pkg::KIND_W-1:0] KIND_UNUSED = 2'd3;

  // Directed rows either carry a typed result or rely on the predictor.
  localparam bit TYPED = 1'b1;
  localparam bit PREDICTED = 1'b0;

  typedef struct {
    logic [pso_pkg::KIND_W-1:0] kind;
    logic [pso_pkg::DIM_W-1:0]  dim;
    logic signed [31:0] lpos;
    logic signed [31:0] lvel;
    logic signed [31:0] gbest;
    logic [15:0]        r1;
    logic [15:0]        r2;
    logic signed [31:0] cost;
  } particle_req_t;

  typedef struct {
    logic signed [31:0] pos;
    logic signed [31:0] vel;
    logic               improved;
    logic               clamped;
  } particle_res_t;

  typedef struct {
    particle_res_t res;
    int            index;
  } awaited_result_t;

  typedef struct {
    int            cfg_set;
    particle_req_t req;
  } directed_row_t;

  // Clock, reset and block ports.
  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  // tdata from bit 0: dim, load_position, load_velocity, global_best,
  // rand_own, rand_global, cost, zero fill.
  logic [pso_pkg::IN_DATA_W-1:0]  s_tdata = '0;
  // tuser from bit 0: kind.
  logic [pso_pkg::KIND_W-1:0]     s_tuser = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  // tdata from bit 0: new_position, new_velocity, improved, clamped, zero fill.
  logic [pso_pkg::OUT_DATA_W-1:0] m_tdata;
  logic                  cfg_we = 1'b0;
  logic [pso_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [pso_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  // Predicted particle state and register copies.
  logic signed [31:0] pos_mem [NUM_DIMS];
  logic signed [31:0] vel_mem [NUM_DIMS];
  logic signed [31:0] best_mem [NUM_DIMS];
  logic signed [31:0] best_cost;
  logic               has_best;
  logic [15:0]        cfg_momentum;
  logic [15:0]        cfg_own_gain;
  logic [15:0]        cfg_swarm_gain;
  logic [15:0]        cfg_vmax_fraction;

  // Results still owed by the block, oldest first.
  awaited_result_t    pending_results[$];
  directed_row_t      directed_rows[$];
  particle_res_t      typed_by_index[int];

  int error_count = 0;
  int accepted_count = 0;
  int results_checked = 0;
  int n_load = 0, n_cost = 0, n_step = 0, n_unused = 0;
  int n_improved = 0, n_clamped = 0, n_settings = 0;
  int cycle_count = 0;
  int ready_hold = 0;
  bit steady_mode = 1'b0;
  logic signed [31:0] cost_floor;

  pso_particle_update uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always #6 clk = ~clk;

  // Run limit in case the block stops answering.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("Timeout after %0d cycles with %0d results outstanding",
               cycle_count, pending_results.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Predictor state after reset.
  initial begin
    for (int d = 0; d < NUM_DIMS; d++) begin
      pos_mem[d] = '0;
      vel_mem[d] = '0;
      best_mem[d] = '0;
    end
    best_cost = pso_pkg::BEST_COST_RESET;
    has_best = 1'b0;
    cfg_momentum = pso_pkg::MOMENTUM_RESET;
    cfg_own_gain = pso_pkg::OWN_BEST_GAIN_RESET;
    cfg_swarm_gain = pso_pkg::SWARM_BEST_GAIN_RESET;
    cfg_vmax_fraction = pso_pkg::VMAX_FRACTION_RESET;
  end

  function automatic logic signed [31:0] saturate_word(longint v);
    if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
    if (v < -64'sd2147483648) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  // One attraction term: gain*rand in Q.16, times the exact distance.
  function automatic longint pull_term(logic [15:0] gain, logic [15:0] rnd,
                                       logic signed [31:0] target,
                                       logic signed [31:0] x);
    longint scaled;
    longint diff;
    scaled = (longint'(gain) * longint'(rnd)) >>> 12;
    diff = longint'(target) - longint'(x);
    return longint'(saturate_word((scaled * diff) >>> 16));
  endfunction

  // A strictly lower cost snapshots the whole position as the personal best.
  function automatic logic offer_cost(logic signed [31:0] c);
    if (c < best_cost) begin
      best_cost = c;
      best_mem = pos_mem;
      has_best = 1'b1;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic particle_res_t predict_particle_result(particle_req_t req);
    particle_res_t res;
    longint x;
    longint sum;
    longint vmax;
    res = '{pos: '0, vel: '0, improved: 1'b0, clamped: 1'b0};
    case (req.kind)
      pso_pkg::KIND_LOAD: begin
        pos_mem[req.dim] = req.lpos;
        vel_mem[req.dim] = req.lvel;
      end
      pso_pkg::KIND_COST: begin
        res.improved = offer_cost(req.cost);
      end
      pso_pkg::KIND_STEP: begin
        // The first step with no best yet takes the current position as best.
        if (!has_best) begin
          void'(offer_cost(req.cost));
          best_mem = pos_mem;
          has_best = 1'b1;
        end
        x = pos_mem[req.dim];
        vmax = longint'(cfg_vmax_fraction) * pso_pkg::VMAX_MULT;
        sum = longint'(saturate_word(
                (longint'(cfg_momentum) * longint'(vel_mem[req.dim])) >>> 12));
        sum += pull_term(cfg_own_gain, req.r1, best_mem[req.dim], pos_mem[req.dim]);
        sum += pull_term(cfg_swarm_gain, req.r2, req.gbest, pos_mem[req.dim]);
        if (sum > vmax) begin
          sum = vmax;
          res.clamped = 1'b1;
        end
        if (sum < -vmax) begin
          sum = -vmax;
          res.clamped = 1'b1;
        end
        vel_mem[req.dim] = sum[31:0];
        pos_mem[req.dim] = saturate_word(x + sum);
      end
      default: begin
      end
    endcase
    res.pos = pos_mem[req.dim];
    res.vel = vel_mem[req.dim];
    return res;
  endfunction

  task automatic flag_error(string msg);
    error_count++;
    if (error_count <= MAX_REPORTS) $display("ERROR: %s", msg);
  endtask

  // Watch both streams and the register port; predict on every accepted
  // request and check every accepted result against the oldest prediction.
  always @(posedge clk) begin : stream_monitor
    particle_req_t   req;
    particle_res_t   got;
    awaited_result_t owed;
    if (!rst) begin
      if (cfg_we) begin
        case (cfg_index)
          pso_pkg::CFG_MOMENTUM:        cfg_momentum = cfg_data;
          pso_pkg::CFG_OWN_BEST_GAIN:   cfg_own_gain = cfg_data;
          pso_pkg::CFG_SWARM_BEST_GAIN: cfg_swarm_gain = cfg_data;
          pso_pkg::CFG_VMAX_FRACTION:   cfg_vmax_fraction = cfg_data;
          default: begin
          end
        endcase
      end
      if (s_tvalid && s_tready) begin
        req.kind = s_tuser;
        req.dim = s_tdata[3:0];
        req.lpos = s_tdata[35:4];
        req.lvel = s_tdata[67:36];
        req.gbest = s_tdata[99:68];
        req.r1 = s_tdata[115:100];
        req.r2 = s_tdata[131:116];
        req.cost = s_tdata[163:132];
        case (req.kind)
          pso_pkg::KIND_LOAD: n_load++;
          pso_pkg::KIND_COST: n_cost++;
          pso_pkg::KIND_STEP: n_step++;
          default:            n_unused++;
        endcase
        owed.res = predict_particle_result(req);
        if (typed_by_index.exists(accepted_count)) owed.res = typed_by_index[accepted_count];
        owed.index = accepted_count;
        accepted_count++;
        pending_results.push_back(owed);
      end
      if (m_tvalid && m_tready) begin
        got.pos = m_tdata[31:0];
        got.vel = m_tdata[63:32];
        got.improved = m_tdata[64];
        got.clamped = m_tdata[65];
        if (pending_results.size() == 0) begin
          flag_error($sformatf("result %h arrived with nothing outstanding", m_tdata));
        end else begin
          owed = pending_results.pop_front();
          results_checked++;
          if (got.improved) n_improved++;
          if (got.clamped) n_clamped++;
          if (got.pos !== owed.res.pos)
            flag_error($sformatf("request %0d: new_position expected %h, got %h",
                                 owed.index, owed.res.pos, got.pos));
          if (got.vel !== owed.res.vel)
            flag_error($sformatf("request %0d: new_velocity expected %h, got %h",
                                 owed.index, owed.res.vel, got.vel));
          if (got.improved !== owed.res.improved)
            flag_error($sformatf("request %0d: improved expected %b, got %b",
                                 owed.index, owed.res.improved, got.improved));
          if (got.clamped !== owed.res.clamped)
            flag_error($sformatf("request %0d: clamped expected %b, got %b",
                                 owed.index, owed.res.clamped, got.clamped));
        end
      end
    end
  end

  // Mostly short gaps, now and then a long one.
  function automatic int gap_len();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 8);
    return $urandom_range(20, 40);
  endfunction

  // Result-side back pressure.
  always @(posedge clk) begin
    if (ready_hold > 0) begin
      m_tready <= 1'b0;
      ready_hold <= ready_hold - 1;
    end else begin
      m_tready <= 1'b1;
      if (!steady_mode) ready_hold <= gap_len();
    end
  end

  function automatic logic [pso_pkg::IN_DATA_W-1:0] pack_request(particle_req_t req);
    return {4'b0, req.cost, req.r2, req.r1, req.gbest, req.lvel, req.lpos, req.dim};
  endfunction

  // Present one request and hold it until the block takes it.
  task automatic send_request(particle_req_t req);
    s_tvalid <= 1'b1;
    s_tuser <= req.kind;
    s_tdata <= pack_request(req);
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic idle_sender(int n);
    if (n > 0) begin
      s_tvalid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // Stop sending until every owed result is back and the block has settled.
  task automatic wait_for_idle();
    s_tvalid <= 1'b0;
    do @(negedge clk); while (pending_results.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write all four registers on consecutive cycles; the block must be idle.
  task automatic set_config(logic [15:0] m, logic [15:0] c1, logic [15:0] c2,
                            logic [15:0] vf);
    logic [15:0] vals [4];
    vals[pso_pkg::CFG_MOMENTUM] = m;
    vals[pso_pkg::CFG_OWN_BEST_GAIN] = c1;
    vals[pso_pkg::CFG_SWARM_BEST_GAIN] = c2;
    vals[pso_pkg::CFG_VMAX_FRACTION] = vf;
    for (int i = 0; i < 4; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= pso_pkg::CFG_IDX_W'(i);
      cfg_data <= vals[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    n_settings++;
  endtask

  task automatic add_row(int cfg_set, logic [pso_pkg::KIND_W-1:0] kind,
                         logic [pso_pkg::DIM_W-1:0] dim,
                         logic signed [31:0] lpos, logic signed [31:0] lvel,
                         logic signed [31:0] gbest, logic [15:0] r1, logic [15:0] r2,
                         logic signed [31:0] cost, bit typed,
                         logic signed [31:0] epos, logic signed [31:0] evel,
                         logic eimp, logic eclp);
    directed_row_t row;
    row.cfg_set = cfg_set;
    row.req = '{kind: kind, dim: dim, lpos: lpos, lvel: lvel, gbest: gbest,
                r1: r1, r2: r2, cost: cost};
    if (typed)
      typed_by_index[directed_rows.size()] =
        '{pos: epos, vel: evel, improved: eimp, clamped: eclp};
    directed_rows.push_back(row);
  endtask

  function automatic logic signed [31:0] near_zero(int bits);
    return int'($urandom_range(0, (2 << bits) - 1)) - (1 << bits);
  endfunction

  // Random request; in wild mode full-range values are mixed in.
  function automatic particle_req_t make_random_request(bit wild);
    particle_req_t req;
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 10) req.kind = pso_pkg::KIND_LOAD;
    else if (roll < 22) req.kind = pso_pkg::KIND_COST;
    else if (roll < 95) req.kind = pso_pkg::KIND_STEP;
    else req.kind = KIND_UNUSED;
    req.dim = pso_pkg::DIM_W'($urandom_range(0, NUM_DIMS - 1));
    req.lpos = (wild && $urandom_range(0, 3) == 0) ? 32'($urandom) : near_zero(23);
    req.lvel = (wild && $urandom_range(0, 3) == 0) ? 32'($urandom) : near_zero(18);
    req.gbest = ($urandom_range(0, 4) == 0) ? 32'($urandom) : near_zero(23);
    req.r1 = 16'($urandom_range(0, 65535));
    req.r2 = 16'($urandom_range(0, 65535));
    req.cost = $urandom;
    // Cost reports follow a falling floor so that improvements keep coming.
    if (req.kind == pso_pkg::KIND_COST && !(wild && $urandom_range(0, 3) == 0)) begin
      if ($urandom_range(0, 99) < 40) begin
        cost_floor = cost_floor - $urandom_range(1, 4096);
        req.cost = cost_floor;
      end else begin
        req.cost = cost_floor + $urandom_range(0, 1 << 20);
      end
    end
    return req;
  endfunction

  // Main stimulus.
  initial begin
    particle_req_t req;
    int cur_set;
    // Directed part: extremes, every kind, first step without a best, cost
    // reports that tie or beat the best, and the unused kind.
    add_row(0, KIND_UNUSED, 4'd0, 0, 0, 0, 0, 0, 0, TYPED, 0, 0, 0, 0);
    add_row(0, pso_pkg::KIND_COST, 4'd0, 0, 0, 0, 0, 0, 32'sh7FFF_FFFF, TYPED, 0, 0, 0, 0);
    add_row(0, pso_pkg::KIND_LOAD, 4'd0, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 0, 0, 0, 0,
            TYPED, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 0, 0);
    add_row(0, pso_pkg::KIND_LOAD, 4'd15, 32'sh8000_0000, 32'sh8000_0000, 0, 0, 0,
            32'sh8000_0000, TYPED, 32'sh8000_0000, 32'sh8000_0000, 0, 0);
    add_row(0, pso_pkg::KIND_LOAD, 4'd3, 32'sh0001_0000, 0, 0, 0, 0, 0,
            TYPED, 32'sh0001_0000, 0, 0, 0);
    add_row(0, pso_pkg::KIND_STEP, 4'd3, 0, 0, 32'sh0005_0000, 16'hFFFF, 16'hFFFF,
            32'sh4000_0000, PREDICTED, 0, 0, 0, 0);
    add_row(0, pso_pkg::KIND_COST, 4'd3, 0, 0, 0, 0, 0, 32'sh4000_0000,
            PREDICTED, 0, 0, 0, 0);
    add_row(0, pso_pkg::KIND_COST, 4'd0, 0, 0, 0, 0, 0, 32'sh3FFF_FFFF,
            TYPED, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1, 0);
    add_row(0, pso_pkg::KIND_STEP, 4'd0, 0, 0, 32'sh8000_0000, 16'h0000, 16'hFFFF,
            32'sh8000_0000, PREDICTED, 0, 0, 0, 0);
    add_row(0, pso_pkg::KIND_STEP, 4'd15, 0, 0, 32'sh7FFF_FFFF, 16'hFFFF, 16'hFFFF, 0,
            PREDICTED, 0, 0, 0, 0);
    add_row(0, pso_pkg::KIND_STEP, 4'd7, 0, 0, 0, 0, 0, 0, TYPED, 0, 0, 0, 0);
    add_row(0, KIND_UNUSED, 4'd15, 0, 0, 0, 0, 0, 0, PREDICTED, 0, 0, 0, 0);
    add_row(0, pso_pkg::KIND_LOAD, 4'd9, 32'sh1234_5678, 32'shFFFF_0000, 0, 0, 0, 0,
            TYPED, 32'sh1234_5678, 32'shFFFF_0000, 0, 0);
    // All registers at their largest value.
    add_row(1, pso_pkg::KIND_STEP, 4'd0, 0, 0, 32'sh8000_0000, 16'hFFFF, 16'hFFFF, 0,
            PREDICTED, 0, 0, 0, 0);
    add_row(1, pso_pkg::KIND_STEP, 4'd15, 0, 0, 32'sh7FFF_FFFF, 16'hFFFF, 16'hFFFF, 0,
            PREDICTED, 0, 0, 0, 0);
    add_row(1, pso_pkg::KIND_STEP, 4'd9, 0, 0, 32'sh7FFF_FFFF, 16'hFFFF, 16'hFFFF, 0,
            PREDICTED, 0, 0, 0, 0);
    add_row(1, pso_pkg::KIND_COST, 4'd9, 0, 0, 0, 0, 0, 32'sh3FFF_FFFE,
            PREDICTED, 0, 0, 0, 0);
    // All registers at zero: no motion and a zero velocity limit.
    add_row(2, pso_pkg::KIND_STEP, 4'd9, 0, 0, 32'sh7FFF_FFFF, 16'hFFFF, 16'hFFFF, 0,
            PREDICTED, 0, 0, 0, 0);
    add_row(2, pso_pkg::KIND_LOAD, 4'd4, 32'sd1000, -32'sd5000, 0, 0, 0, 0,
            TYPED, 32'sd1000, -32'sd5000, 0, 0);
    add_row(2, pso_pkg::KIND_STEP, 4'd4, 0, 0, 32'sh7FFF_FFFF, 16'hFFFF, 16'hFFFF, 0,
            PREDICTED, 0, 0, 0, 0);

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    cur_set = 0;
    foreach (directed_rows[i]) begin
      if (directed_rows[i].cfg_set != cur_set) begin
        wait_for_idle();
        cur_set = directed_rows[i].cfg_set;
        if (cur_set == 1) set_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        else set_config(16'h0000, 16'h0000, 16'h0000, 16'h0000);
      end
      send_request(directed_rows[i].req);
      idle_sender(gap_len());
    end

    // Random phases, each under its own register setting. Each phase loads
    // every dimension first, then runs mostly steps with cost reports mixed in.
    cost_floor = 32'sh3FFF_0000;
    for (int p = 0; p < NUM_PHASES; p++) begin
      wait_for_idle();
      case (p)
        0: set_config(pso_pkg::MOMENTUM_RESET, pso_pkg::OWN_BEST_GAIN_RESET,
                      pso_pkg::SWARM_BEST_GAIN_RESET, pso_pkg::VMAX_FRACTION_RESET);
        1: set_config(16'($urandom_range(0, 4095)), 16'($urandom_range(0, 16383)),
                      16'($urandom_range(0, 16383)), 16'($urandom_range(100, 30000)));
        3: set_config(16'd4096, 16'hFFFF, 16'hFFFF, 16'd1);
        default: set_config(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                            16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
      endcase
      steady_mode = (p == 0);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        req = make_random_request(p == NUM_PHASES - 1);
        if (i < NUM_DIMS) begin
          req.kind = pso_pkg::KIND_LOAD;
          req.dim = pso_pkg::DIM_W'(i);
        end
        send_request(req);
        if (i == PHASE_ITEMS / 2) wait_for_idle();
        else idle_sender(steady_mode ? 0 : gap_len());
      end
    end

    wait_for_idle();
    if (pending_results.size() != 0)
      flag_error($sformatf("%0d results never arrived", pending_results.size()));

    $display("Covered %0d requests (%0d loads, %0d cost reports, %0d steps, %0d unused)",
             accepted_count, n_load, n_cost, n_step, n_unused);
    $display("under %0d register settings; %0d results checked, %0d improved, %0d clamped",
             n_settings + 1, results_checked, n_improved, n_clamped);
    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches found", error_count);
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
